@@ design/sma_pkg.sv @@
package sma_pkg;

   // default capacity of the stack
   localparam int DEPTH_DEFAULT = 16;

   // width of the entry count field on the result channel
   localparam int COUNT_PORT_W = 5;

   // operation codes carried by a request
   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_READ   = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // request transaction
   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] push_value;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic signed [31:0]      result_value;
      status_type              status;
      logic [COUNT_PORT_W-1:0] entry_count;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

@@ design/sma_ifs.sv @@
// request channel
interface sma_req_if import sma_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// response channel
interface sma_rsp_if import sma_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/sma_ctrl.sv @@
module sma_ctrl import sma_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_ready,
   output logic    req_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // output register can take a new result
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/sma_datapath.sv @@
module sma_datapath import sma_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // slot memories
   logic [31:0]      val_mem  [DEPTH];
   logic [PTR_W-1:0] dn_mem   [DEPTH];
   logic [PTR_W-1:0] up_mem   [DEPTH];
   logic [PTR_W-1:0] free_mem [DEPTH];

   // list state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [PTR_W-1:0] top_ff, top_in;
   logic [PTR_W-1:0] mid_ff, mid_in;

   // captured request
   mode_type           mode_ff;
   logic signed [31:0] value_ff;

   // registered read data
   logic [31:0]      val_rd_ff;
   logic [PTR_W-1:0] dna_rd_ff, dnb_rd_ff, up_rd_ff, free_rd_ff;

   // response register
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_PORT_W-1:0] rsp_count_ff, rsp_count_in;

   // write ports
   logic             val_we, dn_we, up_we, free_we;
   logic [PTR_W-1:0] val_wa, dn_wa, dn_wd, up_wa, up_wd, free_wa, free_wd;

   logic [PTR_W-1:0]         val_ra, free_ra;
   logic [CNT_W-1:0]         free_dec;
   logic [PTR_W-1:0]         alloc_slot;
   logic                     use_free, is_empty, is_full, has_below, has_above;
   logic [CNT_W+COUNT_PORT_W-1:0] count_wide;

   assign free_dec   = free_cnt_ff - CNT_W'(1);
   assign free_ra    = free_dec[PTR_W-1:0];
   assign val_ra     = (req_payload.mode == MODE_POP) ? top_ff : mid_ff;
   assign use_free   = (free_cnt_ff != '0);
   assign alloc_slot = use_free ? free_rd_ff : fresh_ff[PTR_W-1:0];
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign has_below  = (count_ff > CNT_W'(1));
   assign has_above  = (mid_ff != top_ff);

   // operation on captured request and read data
   always_comb begin
      top_in        = top_ff;
      mid_in        = mid_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      free_cnt_in   = free_cnt_ff;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      val_we        = 1'b0;
      val_wa        = alloc_slot;
      dn_we         = 1'b0;
      dn_wa         = alloc_slot;
      dn_wd         = top_ff;
      up_we         = 1'b0;
      up_wa         = top_ff;
      up_wd         = alloc_slot;
      free_we       = 1'b0;
      free_wa       = free_cnt_ff[PTR_W-1:0];
      free_wd       = top_ff;
      priority if (mode_ff == MODE_PUSH && is_full) begin
         rsp_status_in = STATUS_FULL;
      end else if (mode_ff == MODE_PUSH) begin
         // link new slot above the top
         val_we = 1'b1;
         dn_we  = 1'b1;
         up_we  = !is_empty;
         if (use_free) begin
            free_cnt_in = free_dec;
         end else begin
            fresh_in = fresh_ff + CNT_W'(1);
         end
         count_in = count_ff + CNT_W'(1);
         top_in   = alloc_slot;
         if (is_empty) begin
            mid_in = alloc_slot;
         end else if (count_ff[0]) begin
            // middle steps up when the new count is even
            mid_in = has_above ? up_rd_ff : alloc_slot;
         end
      end else if (is_empty) begin
         rsp_status_in = STATUS_EMPTY;
      end else begin
         unique case (mode_ff)
            MODE_POP: begin
               rsp_value_in = val_rd_ff;
               if (has_below) begin
                  top_in = dna_rd_ff;
               end
               free_we     = 1'b1;
               free_wd     = top_ff;
               free_cnt_in = free_cnt_ff + CNT_W'(1);
               count_in    = count_ff - CNT_W'(1);
               if (!count_ff[0]) begin
                  mid_in = dnb_rd_ff;
               end
            end
            MODE_READ: begin
               rsp_value_in = val_rd_ff;
            end
            MODE_DELETE: begin
               rsp_value_in = val_rd_ff;
               // unlink the middle slot
               if (has_below && has_above) begin
                  up_we = 1'b1;
                  up_wa = dnb_rd_ff;
                  up_wd = up_rd_ff;
                  dn_we = 1'b1;
                  dn_wa = up_rd_ff;
                  dn_wd = dnb_rd_ff;
               end
               if (has_below && !has_above) begin
                  top_in = dnb_rd_ff;
               end
               free_we     = 1'b1;
               free_wd     = mid_ff;
               free_cnt_in = free_cnt_ff + CNT_W'(1);
               count_in    = count_ff - CNT_W'(1);
               if (has_below) begin
                  mid_in = count_ff[0] ? up_rd_ff : dnb_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign count_wide   = (CNT_W + COUNT_PORT_W)'(count_in);
   assign rsp_count_in = count_wide[COUNT_PORT_W-1:0];

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.commit && val_we) begin
         val_mem[val_wa] <= value_ff;
      end
      if (cmd.commit && dn_we) begin
         dn_mem[dn_wa] <= dn_wd;
      end
      if (cmd.commit && up_we) begin
         up_mem[up_wa] <= up_wd;
      end
      if (cmd.commit && free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      if (cmd.capture) begin
         val_rd_ff  <= val_mem[val_ra];
         dna_rd_ff  <= dn_mem[top_ff];
         dnb_rd_ff  <= dn_mem[mid_ff];
         up_rd_ff   <= up_mem[mid_ff];
         free_rd_ff <= free_mem[free_ra];
      end
   end

   // request capture and response register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_payload.mode;
         value_ff <= req_payload.push_value;
      end
      if (cmd.commit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // list control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         fresh_ff    <= '0;
         free_cnt_ff <= '0;
         top_ff      <= '0;
         mid_ff      <= '0;
      end else if (cmd.commit) begin
         count_ff    <= count_in;
         fresh_ff    <= fresh_in;
         free_cnt_ff <= free_cnt_in;
         top_ff      <= top_in;
         mid_ff      <= mid_in;
      end
   end

   assign rsp_payload.result_value = rsp_value_ff;
   assign rsp_payload.status       = rsp_status_ff;
   assign rsp_payload.entry_count  = rsp_count_ff;

endmodule

@@ design/stack_with_middle_access_unit.sv @@
// Bounded stack of DEPTH signed 32-bit values that can also read or remove
// its middle element (position floor(n/2)+1 counted from the bottom). Every
// request transaction (push, pop, read middle, delete middle) yields exactly
// one response transaction carrying the value, a status and the new count.
// A transaction passes through ST_IDLE and ST_EXEC: accepting a request in
// ST_IDLE issues registered reads of the value, link and free-slot memories,
// ST_EXEC writes the memories back and loads the output register, so a new
// request is taken only once the previous one is loaded; a response stalled
// by the sink holds ST_EXEC until the output register frees. Slots are
// handed out from a fill counter and a free-slot stack, so the memories need
// no clearing pass after reset.
module stack_with_middle_access_unit import sma_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sma_req_if.sink    req_bus,
   sma_rsp_if.source  rsp_bus
);

   cmd_type cmd;

   // sequencing and handshake
   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // list memories and response register
   sma_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_bus.payload),
      .rsp_payload (rsp_bus.payload)
   );

endmodule

@@ design/sma_checker.sv @@
module sma_checker import sma_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [31:0]      rsp_value,
   input status_type              rsp_status,
   input logic [COUNT_PORT_W-1:0] rsp_count
);

   // stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status)
         && $stable(rsp_count))
      else $error("response payload changed while stalled");

   // one transaction in work at a time
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // refused operations return zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_value == 32'sd0)
      else $error("nonzero value with error status");

   // empty status only on an empty stack
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_count == '0)
      else $error("empty status with nonzero count");

endmodule

bind stack_with_middle_access_unit sma_checker u_sma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.payload.result_value),
   .rsp_status(rsp_bus.payload.status),
   .rsp_count (rsp_bus.payload.entry_count)
);

@@ tb/stack_with_middle_access_unit_tb.sv @@
`timescale 1ns / 1ps

module stack_with_middle_access_unit_tb;
   import sma_pkg::*;

   localparam int STACK_DEPTH   = DEPTH_DEFAULT;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_OPS    = 1350;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 1000;

   logic clock;
   logic reset;

   sma_req_if req_if ();
   sma_rsp_if rsp_if ();

   stack_with_middle_access_unit #(
      .DEPTH(STACK_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // operations waiting to be driven, expected responses in order
   req_payload_type    op_queue[$];
   rsp_payload_type    expected_rsps[$];
   // contents of the stack, bottom entry first
   logic signed [31:0] stack_image[$];

   int          mismatches;
   int          rsp_index;
   logic        req_taken;
   int unsigned req_gap;
   int unsigned rsp_hold;
   logic        quiet_phase;
   int unsigned idle_run;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at response %0d: %s", rsp_index, msg);
      mismatches++;
   endtask

   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 8);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic queue_op(input mode_type mode, input logic signed [31:0] value);
      req_payload_type item;
      item.mode       = mode;
      item.push_value = value;
      op_queue.push_back(item);
   endtask

   // stack behavior: one response per operation, middle at index n/2
   task automatic apply_stack_op(input req_payload_type item, output rsp_payload_type rsp);
      int n;
      n = stack_image.size();
      rsp.result_value = '0;
      rsp.status       = STATUS_OK;
      if (item.mode == MODE_PUSH) begin
         if (n >= STACK_DEPTH)
            rsp.status = STATUS_FULL;
         else
            stack_image.push_back(item.push_value);
      end else if (n == 0) begin
         rsp.status = STATUS_EMPTY;
      end else begin
         case (item.mode)
            MODE_POP: begin
               rsp.result_value = stack_image.pop_back();
            end
            MODE_READ: begin
               rsp.result_value = stack_image[n / 2];
            end
            default: begin
               rsp.result_value = stack_image[n / 2];
               stack_image.delete(n / 2);
            end
         endcase
      end
      rsp.entry_count = COUNT_PORT_W'(stack_image.size());
   endtask

   // random push value: an extreme, a small value in -8..7 or any 32-bit value
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         req_gap        <= 0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (op_queue.size() > 0) begin
            req_if.payload <= op_queue.pop_front();
            req_if.valid   <= 1'b1;
            if (quiet_phase || $urandom_range(0, 1) == 0)
               req_gap <= 0;
            else
               req_gap <= idle_cycles();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready driver with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 3) == 0)
            rsp_hold <= idle_cycles();
      end
   end

   // switch now and then into stretches without idling
   always @(negedge clock) begin
      if (reset)
         quiet_phase <= 1'b0;
      else if ($urandom_range(0, 199) == 0)
         quiet_phase <= ~quiet_phase;
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction value %0d status %0d count %0d",
                                         got.result_value, got.status, got.entry_count));
            end else begin
               want = expected_rsps.pop_front();
               if (got.result_value !== want.result_value)
                  report_mismatch($sformatf("result_value got %0d expected %0d",
                                            got.result_value, want.result_value));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            got.status, want.status));
               if (got.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d expected %0d",
                                            got.entry_count, want.entry_count));
            end
            rsp_index++;
         end
         if (req_if.valid && req_if.ready) begin
            apply_stack_op(req_if.payload, want);
            expected_rsps.push_back(want);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         idle_run <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   // stimulus and end of run
   initial begin
      int          generated;
      int          push_pct;
      int          block_len;
      int unsigned r;
      mode_type    m;

      mismatches     = 0;
      rsp_index      = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;

      // empty stack on every removing or reading operation
      queue_op(MODE_POP, 0);
      queue_op(MODE_READ, 0);
      queue_op(MODE_DELETE, 0);
      // delete of the only entry
      queue_op(MODE_PUSH, 32'sh7fffffff);
      queue_op(MODE_READ, 0);
      queue_op(MODE_DELETE, 0);
      // delete where the middle is the top
      queue_op(MODE_PUSH, 32'sh80000000);
      queue_op(MODE_PUSH, -1);
      queue_op(MODE_READ, 0);
      queue_op(MODE_DELETE, 0);
      queue_op(MODE_READ, 0);
      queue_op(MODE_POP, 0);
      // middle movement after deletes with even and odd counts
      queue_op(MODE_PUSH, 0);
      queue_op(MODE_PUSH, 1);
      queue_op(MODE_PUSH, 2);
      queue_op(MODE_PUSH, 3);
      queue_op(MODE_READ, 0);
      queue_op(MODE_DELETE, 0);
      queue_op(MODE_READ, 0);
      queue_op(MODE_DELETE, 0);
      queue_op(MODE_READ, 0);
      queue_op(MODE_POP, 0);
      queue_op(MODE_POP, 0);
      queue_op(MODE_POP, 0);

      // random blocks, push-heavy ones fill the stack, pop-heavy ones drain it
      generated = 0;
      while (generated < RANDOM_OPS) begin
         case ($urandom_range(0, 3))
            0: push_pct = 90;
            1: push_pct = 55;
            2: push_pct = 30;
            default: push_pct = 10;
         endcase
         block_len = $urandom_range(10, 50);
         repeat (block_len) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
               m = MODE_PUSH;
            end else begin
               case ($urandom_range(0, 2))
                  0: m = MODE_POP;
                  1: m = MODE_READ;
                  default: m = MODE_DELETE;
               endcase
            end
            queue_op(m, random_value());
            generated++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every operation to be taken and answered
      do
         @(posedge clock);
      while (op_queue.size() > 0 || req_if.valid || expected_rsps.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
design/sma_pkg.sv
design/sma_ifs.sv
design/sma_ctrl.sv
design/sma_datapath.sv
design/stack_with_middle_access_unit.sv
design/sma_checker.sv
tb/stack_with_middle_access_unit_tb.sv
